>>> hdl/md5sh_pkg.sv
package md5sh_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_FIN,
		ST_OUT
	} state_t;

	// initial chaining words A, B, C, D
	localparam logic [31:0] IV_TAB [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	// per-round additive constants
	localparam logic [31:0] K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotate amounts, indexed by {round group, round[1:0]}
	localparam logic [4:0] ROT_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] FILL_PADND = 6'd55;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [1:0] WORD_LAST  = 2'd3;

endpackage

>>> hdl/md5_stream_hasher_core.sv
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  data_byte, has_byte, end_of_message
// out      source     out_valid/ out_stall digest_word, word_number, final_word
//
// An item that does not fill the block is taken without a stall. Filling the
// 64-byte block starts a compression (one round per cycle on a shared round
// unit) and then the chaining add; no new item is taken until both are done.
// A message end adds the padding and length bytes, the compressions they
// trigger, and four output transfers.
// Reset sets the chaining words to the initial values and clears length and fill.
// in_stall is high while a block is compressed, padded or the digest is shown.
module md5_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_number,
	output logic        final_word
);
	import md5sh_pkg::*;

	state_t      state_q, state_next, ret_q, ret_next;
	logic [31:0] chain_q [4];
	logic [31:0] block_q [16];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] bitlen_q;
	logic [5:0]  fill_q;
	logic [5:0]  round_q;
	logic [1:0]  word_q;
	logic        pad_first_q;

	logic        in_xfer, out_xfer;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic        comp_start;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// next state
	always_comb begin
		state_next = state_q;
		ret_next   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (has_byte && fill_q == FILL_LAST) begin
						state_next = ST_COMP;
						ret_next   = end_of_message ? ST_PAD : ST_IDLE;
					end else if (end_of_message) begin
						state_next = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == FILL_LAST) begin
					state_next = ST_COMP;
					ret_next   = ST_PAD;
				end else if (fill_q == FILL_PADND) begin
					state_next = ST_LEN;
				end
			end
			ST_LEN: begin
				if (fill_q == FILL_LAST) begin
					state_next = ST_COMP;
					ret_next   = ST_OUT;
				end
			end
			ST_COMP: begin
				if (round_q == ROUND_LAST) state_next = ST_FIN;
			end
			ST_FIN: begin
				state_next = ret_q;
			end
			ST_OUT: begin
				if (out_xfer && word_q == WORD_LAST) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs and byte write control
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		wr_en     = 1'b0;
		wr_byte   = data_byte;
		case (state_q)
			ST_IDLE: begin
				wr_en   = in_xfer && has_byte;
				wr_byte = data_byte;
			end
			ST_PAD: begin
				wr_en   = 1'b1;
				wr_byte = pad_first_q ? PAD_BYTE : 8'h00;
			end
			ST_LEN: begin
				wr_en   = 1'b1;
				wr_byte = bitlen_q[{fill_q[2:0], 3'b000} +: 8];
			end
			default: begin
				wr_en   = 1'b0;
				wr_byte = data_byte;
			end
		endcase
	end

	assign comp_start = (state_next == ST_COMP) && (state_q != ST_COMP);

	assign digest_word = chain_q[word_q];
	assign word_number = word_q;
	assign final_word  = (word_q == WORD_LAST);

	// round function of the shared unit
	logic [1:0]  grp;
	logic [31:0] f_val;
	logic [3:0]  g_idx;
	logic [31:0] t_val;
	logic [63:0] rot_wide;
	logic [31:0] b_new;

	always_comb begin
		grp = round_q[5:4];
		case (grp)
			2'd0: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				g_idx = round_q[3:0];
			end
			2'd1: begin
				f_val = (b_q & d_q) | (c_q & ~d_q);
				g_idx = round_q[3:0] * 4'd5 + 4'd1;
			end
			2'd2: begin
				f_val = b_q ^ c_q ^ d_q;
				g_idx = round_q[3:0] * 4'd3 + 4'd5;
			end
			default: begin
				f_val = c_q ^ (b_q | ~d_q);
				g_idx = round_q[3:0] * 4'd7;
			end
		endcase
		t_val    = a_q + f_val + K_TAB[round_q] + block_q[g_idx];
		rot_wide = {t_val, t_val} << ROT_TAB[{grp, round_q[1:0]}];
		b_new    = b_q + rot_wide[63:32];
	end

	// control registers, chaining words and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			fill_q      <= '0;
			bitlen_q    <= '0;
			round_q     <= '0;
			word_q      <= '0;
			pad_first_q <= 1'b0;
			for (int i = 0; i < 4; i++) chain_q[i] <= IV_TAB[i];
		end else begin
			state_q <= state_next;
			ret_q   <= ret_next;
			if (wr_en) fill_q <= fill_q + 6'd1;
			if (in_xfer && has_byte) bitlen_q <= bitlen_q + 64'd8;
			// arm the 0x80 marker on an end transfer, drop it once written
			if (in_xfer && end_of_message) pad_first_q <= 1'b1;
			else if (state_q == ST_PAD) pad_first_q <= 1'b0;
			// advance the round counter
			if (comp_start) round_q <= '0;
			else if (state_q == ST_COMP) round_q <= round_q + 6'd1;
			// fold the working words into the chain
			if (state_q == ST_FIN) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end
			// step through the digest words, then start a fresh message
			if (out_xfer) begin
				word_q <= word_q + 2'd1;
				if (word_q == WORD_LAST) begin
					bitlen_q <= '0;
					for (int i = 0; i < 4; i++) chain_q[i] <= IV_TAB[i];
				end
			end
		end
	end

	// working words and block buffer
	always_ff @(posedge clk) begin
		if (comp_start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == ST_COMP) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_new;
		end
		if (wr_en) block_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= wr_byte;
	end

`ifndef SYNTHESIS
	a_out_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (fill_q == 6'd0))
		else $error("digest shown with a partly filled block");

	a_len_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN) |-> (fill_q[5:3] == 3'b111))
		else $error("length byte outside the last eight slots");

	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && end_of_message) |=> in_stall)
		else $error("input taken while a message is being finished");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && final_word) |=> !out_valid)
		else $error("digest continues past the last word");
`endif

endmodule

>>> bench/md5_stream_hasher_core_test.sv
module md5_stream_hasher_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 70;

	// per-round additive constants of the compression
	localparam logic [31:0] ROUND_ADD [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// left-rotate amounts, indexed by round group and round modulo four
	localparam int ROUND_ROT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	localparam logic [31:0] CHAIN_INIT [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_SLOT  = 6'd56;
	localparam logic [1:0] LAST_WORD = 2'd3;

	class md5_digest_board;
		logic [31:0] chain [4];
		logic [31:0] block [16];
		logic [63:0] bit_count;
		logic [5:0]  fill;
		logic [31:0] due_word [$];
		logic [1:0]  due_number [$];
		logic        due_final [$];
		int          errors;

		function new();
			foreach (block[i])
				block[i] = '0;
			errors = 0;
			restart();
		endfunction

		function void restart();
			foreach (chain[i])
				chain[i] = CHAIN_INIT[i];
			bit_count = '0;
			fill = '0;
		endfunction

		// run the 64 rounds over the block and fold into the chain
		function void compress();
			logic [31:0] a, b, c, d, f, t, rt;
			int i, g, grp, sh;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (i = 0; i < 64; i++) begin
				grp = i / 16;
				case (grp)
					0: begin
						f = (b & c) | (~b & d);
						g = i;
					end
					1: begin
						f = (b & d) | (c & ~d);
						g = (5 * i + 1) % 16;
					end
					2: begin
						f = b ^ c ^ d;
						g = (3 * i + 5) % 16;
					end
					default: begin
						f = c ^ (b | ~d);
						g = (7 * i) % 16;
					end
				endcase
				t = a + f + ROUND_ADD[i] + block[g];
				sh = ROUND_ROT[grp * 4 + i % 4];
				rt = (t << sh) | (t >> (32 - sh));
				a = d;
				d = c;
				c = b;
				b = b + rt;
			end
			chain[0] = chain[0] + a;
			chain[1] = chain[1] + b;
			chain[2] = chain[2] + c;
			chain[3] = chain[3] + d;
		endfunction

		// pack one byte little-endian; compress once the block is full
		function void put_byte(logic [7:0] v);
			block[fill[5:2]][fill[1:0] * 8 +: 8] = v;
			fill = fill + 6'd1;
			if (fill == 6'd0)
				compress();
		endfunction

		// absorb one accepted input transfer; queue the digest on message end
		function void absorb_item(logic [7:0] data, logic with_byte, logic last);
			logic [63:0] len;
			int k;
			if (with_byte) begin
				put_byte(data);
				bit_count = bit_count + 64'd8;
			end
			if (!last)
				return;
			len = bit_count;
			put_byte(PAD_MARK);
			while (fill != LEN_SLOT)
				put_byte(8'h00);
			for (k = 0; k < 8; k++)
				put_byte(len[k * 8 +: 8]);
			for (k = 0; k < 4; k++) begin
				due_word.push_back(chain[k]);
				due_number.push_back(2'(k));
				due_final.push_back(2'(k) == LAST_WORD);
			end
			restart();
		endfunction

		function int pending();
			return due_word.size();
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// compare one output transfer with the oldest queued digest word
		task check_digest_word(logic [31:0] w, logic [1:0] n, logic f);
			logic [31:0] ew;
			logic [1:0]  en;
			logic        ef;
			if (due_word.size() == 0) begin
				report($sformatf("unexpected digest word %08h number %0d", w, n));
				return;
			end
			ew = due_word.pop_front();
			en = due_number.pop_front();
			ef = due_final.pop_front();
			if (w !== ew)
				report($sformatf("digest_word %08h, expected %08h", w, ew));
			if (n !== en)
				report($sformatf("word_number %0d, expected %0d", n, en));
			if (f !== ef)
				report($sformatf("final_word %b, expected %b", f, ef));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [1:0]  word_number;
	logic        final_word;

	md5_digest_board board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;

	md5_stream_hasher_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digest_word    (digest_word),
		.word_number    (word_number),
		.final_word     (final_word)
	);

	always #2ns clk = ~clk;

	// offer one item, idling at random first; return at the edge of its transfer
	task send_item(logic [7:0] data, logic with_byte, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= data;
		has_byte <= with_byte;
		end_of_message <= last;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		board.absorb_item(data, with_byte, last);
	endtask

	// drop valid and hold off until every queued digest word has come out
	task wait_until_drained();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// mostly short messages, some on the padding boundaries, a few long ones
	function int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(12);
		if (r < 80) begin
			case ($urandom_range(7))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				5: return 65;
				6: return 119;
				default: return 120;
			endcase
		end
		if (r < 95)
			return $urandom_range(54, 13);
		return $urandom_range(130, 100);
	endfunction

	// send one message of random bytes with the odd idle item mixed in
	task send_random_message(int len);
		int i;
		bit byte_on_end;
		byte_on_end = (len > 0) && ($urandom_range(1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, byte_on_end && (i == len - 1));
			items_sent++;
		end
		if (!byte_on_end) begin
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
			items_sent++;
		end
	endtask

	// output side: check each transfer, then pick the next stall
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
				board.check_digest_word(digest_word, word_number, final_word);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// end the run when no transfer happens for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("md5_stream_hasher_core_test: done, errors");
		$finish;
	end

	initial begin
		int phase;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message straight out of reset
		send_item(8'h00, 1'b0, 1'b1);
		// "abc", end together with the last byte
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// idle items leave the state alone
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		// extreme bytes, then an end without a byte
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
		// one-byte messages carrying the extremes
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		// back-to-back empty messages
		send_item(8'h5a, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);
		wait_until_drained();

		// hold the output off while short messages back up the input
		hold_request = 1'b1;
		repeat (4)
			send_random_message($urandom_range(6));
		wait_until_drained();

		// random messages under each idling pattern
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			items_sent = 0;
			while (items_sent < PHASE_ITEMS)
				send_random_message(pick_length());
			wait_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("md5_stream_hasher_core_test: done, clean");
		else
			$display("md5_stream_hasher_core_test: done, errors");
		$finish;
	end

endmodule
